// ===== rtl/rrte_pkg.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// rrte_pkg
// Shared constants, codes and types of the RIP route table engine.
//------------------------------------------------------------------------------
package rrte_pkg;

	localparam int TableEntries = 32;
	localparam int Neighbors    = 4;
	localparam int IdxW         = $clog2(TableEntries);
	localparam int CntW         = $clog2(TableEntries + 1);

	localparam logic [4:0] InfMetric = 5'd16;
	localparam logic [9:0] AgeMax    = 10'd1023;

	localparam int InW   = 48;
	localparam int OutW  = 48;
	localparam int UserW = 1;

	typedef enum logic [1:0] {
		OP_RECV = 2'd0,
		OP_TICK = 2'd1,
		OP_DUMP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NOCHG   = 3'd0,
		ST_REFRESH = 3'd1,
		ST_UPDATE  = 3'd2,
		ST_WITHDR  = 3'd3,
		ST_ADDED   = 3'd4,
		ST_BADSRC  = 3'd5,
		ST_FULL    = 3'd6,
		ST_TICK    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		CFG_OWN     = 3'd0,
		CFG_NB_IDS  = 3'd1,
		CFG_NB_COST = 3'd2,
		CFG_NB_EN   = 3'd3,
		CFG_TIMEOUT = 3'd4,
		CFG_GARBAGE = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_PROC,
		S_OWN,
		S_RESULT
	} state_t;

	// One stored route entry
	typedef struct packed {
		logic [15:0] dest;
		logic [15:0] hop;
		logic [4:0]  metric;
		logic        garbage;
		logic [9:0]  age;
	} route_t;

endpackage : rrte_pkg
`default_nettype wire

// ===== rtl/rip_route_table_engine.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// rip_route_table_engine
// Distance-vector route table with receive merge, aging tick and table dump.
//------------------------------------------------------------------------------
// Usage:
//  s_axis carries one operation per transfer (receive, tick, dump); m_axis
//  returns its results, tlast on the final one. cfg_* writes a register; the user must
//  write it only while no operation is in flight, which the block does not enforce.
//  Route entries live in one synchronous memory of TableEntries words
//  (registered read); valid bits sit in flip-flops.
//  Receive and tick walk all TableEntries slots, one slot per cycle (receive
//  reads every slot, tick only valid ones), then drain the read pipe. When
//  the destination is known, the matched slot is read again and written
//  back if the merge calls for it. A rejected source or own destination
//  ends the walk early, and an unknown operation goes straight to its
//  status result. A dump emits the own route first and then the stored
//  entries as the walk reads them. The next item is taken in the cycle
//  after the status result is loaded, or after a dump walk ends.
//  One item is in flight at a time; a stalled receiver holds a dump walk
//  and a waiting status result.
//  Reset empties the table (valid bits clear) and loads register defaults.
//------------------------------------------------------------------------------
module rip_route_table_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: operation[1:0], source_router[17:2], destination[33:18],
	//        received_metric[38:34], neighbor_slot[40:39], zero fill
	input  wire logic [rrte_pkg::InW-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// tdata: status[2:0], triggered_update[3], removed_count[9:4],
	//        entry_destination[25:10], entry_metric[30:26],
	//        entry_next_hop[46:31], zero fill
	output logic [rrte_pkg::OutW-1:0]      m_axis_tdata,
	// tuser: kind
	output logic [rrte_pkg::UserW-1:0]     m_axis_tuser,
	output logic                           m_axis_tlast,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [63:0]               cfg_data
);
	import rrte_pkg::*;

	// configuration registers
	logic [15:0] own_q;
	logic [63:0] nb_ids_q;
	logic [19:0] nb_cost_q;
	logic [3:0]  nb_en_q;
	logic [9:0]  timeout_q, garbage_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q     <= 16'd1;
			nb_ids_q  <= '0;
			nb_cost_q <= '0;
			nb_en_q   <= '0;
			timeout_q <= 10'd120;
			garbage_q <= 10'd180;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OWN:     own_q     <= cfg_data[15:0];
				CFG_NB_IDS:  nb_ids_q  <= cfg_data;
				CFG_NB_COST: nb_cost_q <= cfg_data[19:0];
				CFG_NB_EN:   nb_en_q   <= cfg_data[3:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[9:0];
				CFG_GARBAGE: garbage_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// route memory
	route_t mem [TableEntries];
	route_t rd_s2;
	logic   mem_we;
	logic [IdxW-1:0] mem_waddr, mem_raddr;
	route_t mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_s2 <= mem[mem_raddr];
	end

	// control state
	state_t state_q, state_d;
	op_t    op_q;
	logic [15:0] src_q, dst_q;
	logic [4:0]  rmet_q;
	logic [1:0]  slot_q;
	logic [TableEntries-1:0] valid_q;
	logic [CntW-1:0] cnt_q;          // read pointer of the walk
	logic            pv_s1;          // a read was issued and its word is pending
	logic [IdxW-1:0] pidx_s1;
	logic            found_q, free_q;
	logic [IdxW-1:0] fidx_q, freeidx_q;
	logic            phase2_q;       // receive: matched slot re-read
	logic            trig_q;
	logic [CntW-1:0] rem_q;
	logic [2:0]      st_q;
	logic            ov_q;
	logic [47:0]     od_q;
	logic            ok_q, olast_q;

	// neighbor lookup of the source
	logic       src_ok;
	logic [4:0] src_cost;
	always_comb begin
		src_ok   = 1'b0;
		src_cost = '0;
		for (int s = Neighbors - 1; s >= 0; s--) begin
			if (nb_en_q[s] && nb_ids_q[16*s +: 16] == src_q) begin
				src_ok   = 1'b1;
				src_cost = nb_cost_q[5*s +: 5];
			end
		end
	end
	logic [5:0] msum;
	logic [4:0] mnew;
	assign msum = {1'b0, rmet_q} + {1'b0, src_cost};
	assign mnew = (msum > {1'b0, InfMetric}) ? InfMetric : msum[4:0];

	// poison reverse target
	logic        poison;
	logic [15:0] target;
	assign poison = nb_en_q[slot_q];
	assign target = nb_ids_q[{slot_q, 4'd0} +: 16];

	logic out_free;
	assign out_free = !ov_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	logic walk_done;
	assign walk_done = (cnt_q == CntW'(TableEntries));

	// tick aging of the word read last cycle
	route_t  aged;
	logic    aged_to_garb, aged_del;
	always_comb begin
		aged = rd_s2;
		aged_to_garb = 1'b0;
		aged_del = 1'b0;
		if (rd_s2.age < AgeMax) aged.age = rd_s2.age + 10'd1;
		if (!rd_s2.garbage) begin
			if (aged.age >= timeout_q) begin
				aged_to_garb = 1'b1;
				aged.metric = InfMetric;
				aged.garbage = 1'b1;
				aged.age = '0;
			end
		end else if (aged.age >= garbage_q) begin
			aged_del = 1'b1;
		end
	end

	// receive merge decision on the re-read matched slot
	route_t  mrg;
	logic    mrg_we, mrg_trig;
	logic [2:0] mrg_st;
	always_comb begin
		mrg = rd_s2;
		mrg_we = 1'b0;
		mrg_trig = 1'b0;
		mrg_st = ST_NOCHG;
		if (rd_s2.garbage) begin
			if (mnew < InfMetric) begin
				mrg_we = 1'b1; mrg_st = ST_UPDATE;
			end
		end else if (rd_s2.hop == src_q) begin
			if (rd_s2.metric == mnew) begin
				mrg_we = 1'b1; mrg_st = ST_REFRESH;
				mrg.age = '0;
			end else if (mnew >= InfMetric) begin
				mrg_we = 1'b1; mrg_st = ST_WITHDR; mrg_trig = 1'b1;
				mrg.metric = InfMetric; mrg.garbage = 1'b1; mrg.age = '0;
			end else begin
				mrg_we = 1'b1; mrg_st = ST_UPDATE;
			end
		end else if (rd_s2.metric > mnew) begin
			mrg_we = 1'b1; mrg_st = ST_UPDATE;
		end
		if (mrg_st == ST_UPDATE) begin
			mrg.hop = src_q; mrg.metric = mnew; mrg.garbage = 1'b0; mrg.age = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_axis_tvalid) begin
				state_d = (op_t'(s_axis_tdata[1:0]) == OP_DUMP) ? S_OWN :
					(op_t'(s_axis_tdata[1:0]) == OP_NONE) ? S_RESULT : S_READ;
			end
			S_OWN:    if (out_free) state_d = S_READ;
			S_READ: begin
				if (op_q == OP_RECV && (!src_ok || src_q == own_q || dst_q == own_q))
					state_d = S_RESULT;
				else if (walk_done && !pv_s1) state_d = S_PROC;
			end
			S_PROC: begin
				if (op_q == OP_DUMP) state_d = S_IDLE;
				else if (op_q == OP_TICK || !found_q || phase2_q) state_d = S_RESULT;
			end
			S_RESULT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory addressing and tick/receive write-back
	logic dump_emit;
	assign dump_emit = (op_q == OP_DUMP) && pv_s1;
	logic stall;
	assign stall = dump_emit && !out_free;
	logic issue;
	assign issue = (state_q == S_READ) && !walk_done && !stall &&
		(valid_q[cnt_q[IdxW-1:0]] || op_q == OP_RECV);

	// load the output register with a new result
	logic ov_load;
	assign ov_load = ((state_q == S_OWN || state_q == S_RESULT) && out_free) ||
		(state_q == S_READ && dump_emit && !stall);

	always_comb begin
		mem_raddr = cnt_q[IdxW-1:0];
		if (state_q == S_PROC) mem_raddr = fidx_q;
		// hold the read word of a dump entry that waits for the receiver
		if (stall) mem_raddr = pidx_s1;
		mem_we = 1'b0;
		mem_waddr = pidx_s1;
		mem_wdata = aged;
		if (op_q == OP_TICK && pv_s1 && state_q == S_READ) mem_we = 1'b1;
		if (state_q == S_PROC && op_q == OP_RECV && !found_q && free_q &&
			mnew < InfMetric) begin
			mem_we = 1'b1;
			mem_waddr = freeidx_q;
			mem_wdata = '{dest: dst_q, hop: src_q, metric: mnew, garbage: 1'b0, age: '0};
		end
		if (state_q == S_PROC && phase2_q && mrg_we) begin
			mem_we = 1'b1;
			mem_waddr = fidx_q;
			mem_wdata = mrg;
		end
	end

	// lowest free slot
	logic            anyfree;
	logic [IdxW-1:0] lowfree;
	always_comb begin
		anyfree = 1'b0;
		lowfree = '0;
		for (int i = TableEntries - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				anyfree = 1'b1;
				lowfree = IdxW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			cnt_q    <= '0;
			pv_s1    <= 1'b0;
			ov_q     <= 1'b0;
			found_q  <= 1'b0;
			phase2_q <= 1'b0;
			trig_q   <= 1'b0;
			rem_q    <= '0;
			st_q     <= ST_NOCHG;
			op_q     <= OP_NONE;
		end else begin
			state_q <= state_d;
			if (ov_load) ov_q <= 1'b1;
			else if (ov_q && m_axis_tready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					op_q     <= op_t'(s_axis_tdata[1:0]);
					src_q    <= s_axis_tdata[17:2];
					dst_q    <= s_axis_tdata[33:18];
					rmet_q   <= s_axis_tdata[38:34];
					slot_q   <= s_axis_tdata[40:39];
					cnt_q    <= '0;
					pv_s1    <= 1'b0;
					found_q  <= 1'b0;
					phase2_q <= 1'b0;
					trig_q   <= 1'b0;
					rem_q    <= '0;
					st_q     <= ST_NOCHG;
				end
				S_OWN: if (out_free) begin
					ok_q    <= 1'b1;
					olast_q <= (valid_q == '0);
					od_q    <= {1'b0, own_q,
						(poison && own_q == target) ? InfMetric : 5'd0, own_q, 10'd0};
				end
				S_READ: if (!stall) begin
					pv_s1   <= issue;
					pidx_s1 <= cnt_q[IdxW-1:0];
					if (!walk_done) cnt_q <= cnt_q + 1'b1;
					if (pv_s1) begin
						case (op_q)
							OP_RECV: if (!found_q && valid_q[pidx_s1] &&
								rd_s2.dest == dst_q) begin
								found_q <= 1'b1;
								fidx_q  <= pidx_s1;
							end
							OP_TICK: begin
								if (aged_to_garb) trig_q <= 1'b1;
								if (aged_del) begin
									valid_q[pidx_s1] <= 1'b0;
									rem_q <= rem_q + 1'b1;
								end
							end
							OP_DUMP: begin
								ok_q    <= 1'b1;
								olast_q <= !(|(valid_q >> pidx_s1 >> 1));
								od_q    <= {1'b0, rd_s2.hop,
									(poison && rd_s2.hop == target) ? InfMetric : rd_s2.metric,
									rd_s2.dest, 10'd0};
							end
							default: ;
						endcase
					end
					if (op_q == OP_RECV && (!src_ok || src_q == own_q))
						st_q <= ST_BADSRC;
					free_q    <= anyfree;
					freeidx_q <= lowfree;
				end
				S_PROC: begin
					if (op_q == OP_TICK) st_q <= ST_TICK;
					else if (op_q == OP_RECV) begin
						if (!found_q) begin
							if (mnew >= InfMetric) st_q <= ST_NOCHG;
							else if (free_q) begin
								st_q <= ST_ADDED;
								valid_q[freeidx_q] <= 1'b1;
							end else st_q <= ST_FULL;
						end else if (!phase2_q) begin
							phase2_q <= 1'b1;
						end else begin
							st_q   <= mrg_st;
							trig_q <= mrg_trig;
						end
					end
				end
				S_RESULT: if (out_free) begin
					ok_q    <= 1'b0;
					olast_q <= 1'b1;
					od_q    <= {38'd0, (op_q == OP_TICK) ? 6'(rem_q) : 6'd0,
						(op_q == OP_NONE) ? 1'b0 : trig_q,
						(op_q == OP_NONE) ? ST_NOCHG : status_t'(st_q)};
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tuser  = ok_q;
	assign m_axis_tlast  = olast_q;

`ifndef NO_ASSERTIONS
	// an accepted item always leaves the idle state
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
		else $error("accept did not start an operation");
	// a status result never carries dump payload
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[47:10] == '0))
		else $error("status result with entry fields");
	// a status result always closes its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("status result without tlast");
`endif

endmodule : rip_route_table_engine
`default_nettype wire
